// ===== sv/laser_line_peak_centroid_core_assert.svh =====
// ----------------------------------------------------------------------------
// laser line peak centroid assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef LASER_LINE_PEAK_CENTROID_CORE_ASSERT_SVH
`define LASER_LINE_PEAK_CENTROID_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// check sampled on the clock, switched off while reset is asserted
`define LLPC_ASSERT(lbl, ck, rs, pr) \
  lbl: assert property (@(posedge ck) disable iff (!rs) pr) \
    else $error("llpc assertion failed");

// check that also holds across reset
`define LLPC_ASSERT_RST(lbl, ck, pr) \
  lbl: assert property (@(posedge ck) pr) \
    else $error("llpc reset assertion failed");

`else

`define LLPC_ASSERT(lbl, ck, rs, pr)
`define LLPC_ASSERT_RST(lbl, ck, pr)

`endif

`endif

// ===== sv/llpc_pkg.sv =====
// ----------------------------------------------------------------------------
// llpc_pkg
// sizes, register map and shared types of the laser line peak centroid core
// ----------------------------------------------------------------------------
package llpc_pkg;

  localparam int LINE_LEN  = 1024;
  localparam int FRAC_BITS = 4;

  localparam int SAMPLE_W = 8;
  localparam int IDX_W    = $clog2(LINE_LEN);
  localparam int CNT_W    = $clog2(LINE_LEN + 1);
  localparam int LINE_W   = 12;
  localparam int OFS_W    = 12;
  localparam int COORD_W  = 13;
  localparam int POS_W    = 17;

  localparam int PROD_W = SAMPLE_W + IDX_W;
  localparam int VACC_W = SAMPLE_W + IDX_W;
  localparam int WACC_W = SAMPLE_W + 2 * IDX_W;
  localparam int DIV_W  = WACC_W + FRAC_BITS;
  localparam int QUO_W  = IDX_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(QUO_W + 1);

  localparam int PSUM_W = ((QUO_W > OFS_W + FRAC_BITS) ? QUO_W : OFS_W + FRAC_BITS) + 1;
  localparam int SAT_W  = (PSUM_W > POS_W) ? PSUM_W : POS_W;

  localparam logic [POS_W-1:0] POS_MAX   = '1;
  localparam logic [QUO_W-1:0] FRAC_MASK = QUO_W'((1 << FRAC_BITS) - 1);

  // apb register map
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int REG_SEL_W = 2;

  localparam logic [REG_SEL_W-1:0] REG_MIN_LEVEL   = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_LINE_OFFSET = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_POS_OFFSET  = 2'd2;
  localparam logic [REG_SEL_W-1:0] REG_INTEGER_POS = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] min_level;
    logic [OFS_W-1:0]    line_offset;
    logic [OFS_W-1:0]    pos_offset;
    logic                integer_position;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    min_level:        8'd10,
    line_offset:      '0,
    pos_offset:       '0,
    integer_position: 1'b1
  };

  // sample stays inside the span while 5*v > 4*peak
  function automatic logic passes(input logic [SAMPLE_W-1:0] v,
                                  input logic [SAMPLE_W-1:0] pk);
    logic [SAMPLE_W+2:0] v5;
    logic [SAMPLE_W+2:0] pk4;
    v5  = {3'b000, v} + {1'b0, v, 2'b00};
    pk4 = {1'b0, pk, 2'b00};
    return v5 > pk4;
  endfunction

endpackage

// ===== sv/llpc_ram.sv =====
// ----------------------------------------------------------------------------
// llpc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module llpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/llpc_cfg.sv =====
// ----------------------------------------------------------------------------
// llpc_cfg
// apb register file holding threshold, offsets and position mode
// ----------------------------------------------------------------------------
module llpc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [llpc_pkg::ADDR_W-1:0] paddr,
  input  logic [llpc_pkg::DATA_W-1:0] pwdata,
  output logic [llpc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output llpc_pkg::cfg_t             cfg
);

  llpc_pkg::cfg_t cfg_r;
  llpc_pkg::cfg_t cfg_nxt;
  logic           wr_en;
  logic [llpc_pkg::REG_SEL_W-1:0] sel;

  assign sel    = paddr[llpc_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (sel)
        llpc_pkg::REG_MIN_LEVEL:   cfg_nxt.min_level = pwdata[llpc_pkg::SAMPLE_W-1:0];
        llpc_pkg::REG_LINE_OFFSET: cfg_nxt.line_offset = pwdata[llpc_pkg::OFS_W-1:0];
        llpc_pkg::REG_POS_OFFSET:  cfg_nxt.pos_offset = pwdata[llpc_pkg::OFS_W-1:0];
        llpc_pkg::REG_INTEGER_POS: cfg_nxt.integer_position = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      llpc_pkg::REG_MIN_LEVEL:   prdata = llpc_pkg::DATA_W'(cfg_r.min_level);
      llpc_pkg::REG_LINE_OFFSET: prdata = llpc_pkg::DATA_W'(cfg_r.line_offset);
      llpc_pkg::REG_POS_OFFSET:  prdata = llpc_pkg::DATA_W'(cfg_r.pos_offset);
      llpc_pkg::REG_INTEGER_POS: prdata = llpc_pkg::DATA_W'(cfg_r.integer_position);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= llpc_pkg::CFG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/llpc_div.sv =====
// ----------------------------------------------------------------------------
// llpc_div
// restoring divider, one quotient bit per cycle, for the centroid quotient
// ----------------------------------------------------------------------------
module llpc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [llpc_pkg::DIV_W-1:0]  dividend,
  input  logic [llpc_pkg::VACC_W-1:0] divisor,
  output logic                        done,
  output logic [llpc_pkg::QUO_W-1:0]  quotient
);

  logic [llpc_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [llpc_pkg::DIV_W-1:0]  dsr_r, dsr_nxt;
  logic [llpc_pkg::QUO_W-1:0]  quo_r, quo_nxt;
  logic [llpc_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [llpc_pkg::DIV_W:0]    diff;
  logic                        ge;

  assign diff = {1'b0, rem_r} - {1'b0, dsr_r};
  assign ge   = !diff[llpc_pkg::DIV_W];

  always_comb begin
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = dividend;
      dsr_nxt = llpc_pkg::DIV_W'(divisor) << (llpc_pkg::QUO_W - 1);
      quo_nxt = '0;
      cnt_nxt = llpc_pkg::DCNT_W'(llpc_pkg::QUO_W - 1);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? diff[llpc_pkg::DIV_W-1:0] : rem_r;
      quo_nxt = (quo_r << 1) | llpc_pkg::QUO_W'(ge);
      dsr_nxt = dsr_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== sv/laser_line_peak_centroid_core.sv =====
// ----------------------------------------------------------------------------
// laser_line_peak_centroid_core
// Samples of one image line arrive on the in_ channel, one transfer a cycle while in_stall is low,
// and are written to the line ram while the first maximum is tracked.
// in_start_of_frame restarts the line counter; in_last_of_line closes a line.
// After the closing transfer in_stall stays high while the line is evaluated:
// a walk outwards from the peak reads the ram one sample a cycle and
// accumulates the weighted sums, then a bit-serial divider forms the centroid.
// Evaluation passes S_START, the left walk, S_RSET, the right walk, S_DRAIN,
// the divider and S_FIN, then one result transfer of line coordinate and
// position is offered on the out_ channel.
// Lines whose peak is below min_level or zero give no transfer; S_START returns to S_IDLE.
// A result waits in the output register while out_stall is high; the next
// line can load meanwhile, and its evaluation holds at the end until taken.
// Reset (synchronous, rst_n low) clears the line and frame counters, the peak
// tracker and any pending result; the ram needs no clearing.
// ----------------------------------------------------------------------------
`include "laser_line_peak_centroid_core_assert.svh"

module laser_line_peak_centroid_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [llpc_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          in_last_of_line,
  input  logic                          in_start_of_frame,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [llpc_pkg::COORD_W-1:0]  out_line_coord,
  output logic [llpc_pkg::POS_W-1:0]    out_position,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [llpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [llpc_pkg::DATA_W-1:0]   pwdata,
  output logic [llpc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_LEFT  = 3'd2;
  localparam logic [2:0] S_RSET  = 3'd3;
  localparam logic [2:0] S_RIGHT = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  llpc_pkg::cfg_t cfg;

  logic [2:0] state_r, state_nxt;

  // line loading
  logic [llpc_pkg::CNT_W-1:0]    sample_count_r, sample_count_nxt;
  logic [llpc_pkg::SAMPLE_W-1:0] peak_value_r, peak_value_nxt;
  logic [llpc_pkg::IDX_W-1:0]    peak_index_r, peak_index_nxt;
  logic [llpc_pkg::LINE_W-1:0]   line_count_r, line_count_nxt;

  // line under evaluation
  logic [llpc_pkg::SAMPLE_W-1:0] pk_r, pk_nxt;
  logic [llpc_pkg::IDX_W-1:0]    pi_r, pi_nxt;
  logic [llpc_pkg::IDX_W-1:0]    last_r, last_nxt;
  logic [llpc_pkg::LINE_W-1:0]   lc_r, lc_nxt;

  // ram walk
  logic                       iss_act_r, iss_act_nxt;
  logic [llpc_pkg::IDX_W-1:0] iss_idx_r, iss_idx_nxt;
  logic                       chk_vld_r, chk_vld_nxt;
  logic [llpc_pkg::IDX_W-1:0] chk_idx_r, chk_idx_nxt;

  // product stage and accumulators
  logic                          prod_vld_r, prod_vld_nxt;
  logic [llpc_pkg::PROD_W-1:0]   prod_w_r, prod_w_nxt;
  logic [llpc_pkg::SAMPLE_W-1:0] prod_v_r, prod_v_nxt;
  logic [llpc_pkg::WACC_W-1:0]   wacc_r, wacc_nxt;
  logic [llpc_pkg::VACC_W-1:0]   vacc_r, vacc_nxt;

  // result register
  logic                         out_valid_r, out_valid_nxt;
  logic [llpc_pkg::COORD_W-1:0] out_coord_r, out_coord_nxt;
  logic [llpc_pkg::POS_W-1:0]   out_pos_r, out_pos_nxt;

  logic                          in_acc;
  logic [llpc_pkg::CNT_W-1:0]    cnt_base, cnt_upd, cnt_m1;
  logic [llpc_pkg::SAMPLE_W-1:0] pkv_base, pkv_upd;
  logic [llpc_pkg::IDX_W-1:0]    pki_base, pki_upd;
  logic [llpc_pkg::LINE_W-1:0]   lc_base;
  logic                          in_range, take_peak;

  logic                          ram_we, ram_re;
  logic [llpc_pkg::SAMPLE_W-1:0] ram_rdata;
  logic                          walking, chk_pass, chk_bound, chk_stop;
  logic                          reject;
  logic [llpc_pkg::SAMPLE_W-1:0] mul_v;
  logic [llpc_pkg::IDX_W-1:0]    mul_i;

  logic                        div_start, div_done;
  logic [llpc_pkg::DIV_W-1:0]  div_dividend;
  logic [llpc_pkg::QUO_W-1:0]  div_quo;
  logic [llpc_pkg::QUO_W-1:0]  cent;
  logic [llpc_pkg::SAT_W-1:0]  psum;
  logic [llpc_pkg::POS_W-1:0]  pos_sat;
  logic                        out_take;

  llpc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // loading path
  assign cnt_base  = in_start_of_frame ? '0 : sample_count_r;
  assign pkv_base  = in_start_of_frame ? '0 : peak_value_r;
  assign pki_base  = in_start_of_frame ? '0 : peak_index_r;
  assign lc_base   = in_start_of_frame ? '0 : line_count_r;
  assign in_range  = cnt_base < llpc_pkg::CNT_W'(llpc_pkg::LINE_LEN);
  assign take_peak = in_range && ((cnt_base == '0) || (in_sample > pkv_base));
  assign pkv_upd   = take_peak ? in_sample : pkv_base;
  assign pki_upd   = take_peak ? cnt_base[llpc_pkg::IDX_W-1:0] : pki_base;
  assign cnt_upd   = in_range ? cnt_base + 1'b1 : cnt_base;
  assign cnt_m1    = cnt_upd - 1'b1;
  assign ram_we    = in_acc && in_range;

  // walk path
  assign walking   = (state_r == S_LEFT) || (state_r == S_RIGHT);
  assign ram_re    = walking && iss_act_r;
  assign chk_pass  = llpc_pkg::passes(ram_rdata, pk_r);
  assign chk_bound = (state_r == S_LEFT) ? (chk_idx_r == '0) : (chk_idx_r == last_r);
  assign chk_stop  = chk_vld_r && (!chk_pass || chk_bound);
  assign reject    = (pk_r < cfg.min_level) || (pk_r == '0);

  llpc_ram #(
    .WIDTH (llpc_pkg::SAMPLE_W),
    .DEPTH (llpc_pkg::LINE_LEN)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_base[llpc_pkg::IDX_W-1:0]),
    .wdata (in_sample),
    .re    (ram_re),
    .raddr (iss_idx_r),
    .rdata (ram_rdata)
  );

  assign mul_v = (state_r == S_START) ? pk_r : ram_rdata;
  assign mul_i = (state_r == S_START) ? pi_r : chk_idx_r;

  // divider fed from the final accumulator values
  assign div_start    = (state_r == S_DRAIN);
  assign div_dividend = {wacc_nxt, {llpc_pkg::FRAC_BITS{1'b0}}};

  llpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (vacc_nxt),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign cent    = cfg.integer_position ? (div_quo & ~llpc_pkg::FRAC_MASK) : div_quo;
  assign psum    = llpc_pkg::SAT_W'(cent)
                 + (llpc_pkg::SAT_W'(cfg.pos_offset) << llpc_pkg::FRAC_BITS);
  assign pos_sat = (psum > llpc_pkg::SAT_W'(llpc_pkg::POS_MAX)) ? llpc_pkg::POS_MAX
                                                               : psum[llpc_pkg::POS_W-1:0];
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    state_nxt        = state_r;
    sample_count_nxt = sample_count_r;
    peak_value_nxt   = peak_value_r;
    peak_index_nxt   = peak_index_r;
    line_count_nxt   = line_count_r;
    pk_nxt           = pk_r;
    pi_nxt           = pi_r;
    last_nxt         = last_r;
    lc_nxt           = lc_r;
    iss_act_nxt      = iss_act_r;
    iss_idx_nxt      = iss_idx_r;
    chk_vld_nxt      = chk_vld_r;
    chk_idx_nxt      = chk_idx_r;
    prod_vld_nxt     = 1'b0;
    prod_w_nxt       = llpc_pkg::PROD_W'(mul_v) * llpc_pkg::PROD_W'(mul_i);
    prod_v_nxt       = mul_v;
    wacc_nxt         = prod_vld_r ? wacc_r + llpc_pkg::WACC_W'(prod_w_r) : wacc_r;
    vacc_nxt         = prod_vld_r ? vacc_r + llpc_pkg::VACC_W'(prod_v_r) : vacc_r;
    out_valid_nxt    = out_valid_r && !out_take;
    out_coord_nxt    = out_coord_r;
    out_pos_nxt      = out_pos_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_last_of_line) begin
            sample_count_nxt = '0;
            peak_value_nxt   = '0;
            peak_index_nxt   = '0;
            line_count_nxt   = lc_base + 1'b1;
            pk_nxt           = pkv_upd;
            pi_nxt           = pki_upd;
            last_nxt         = cnt_m1[llpc_pkg::IDX_W-1:0];
            lc_nxt           = lc_base;
            state_nxt        = S_START;
          end else begin
            sample_count_nxt = cnt_upd;
            peak_value_nxt   = pkv_upd;
            peak_index_nxt   = pki_upd;
            line_count_nxt   = lc_base;
          end
        end
      end
      S_START: begin
        wacc_nxt    = '0;
        vacc_nxt    = '0;
        chk_vld_nxt = 1'b0;
        if (reject) begin
          iss_act_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end else begin
          // peak sample enters the sums directly
          prod_vld_nxt = 1'b1;
          if (pi_r != '0) begin
            iss_idx_nxt = pi_r - 1'b1;
            iss_act_nxt = 1'b1;
            state_nxt   = S_LEFT;
          end else begin
            iss_act_nxt = 1'b0;
            state_nxt   = S_RSET;
          end
        end
      end
      S_LEFT, S_RIGHT: begin
        prod_vld_nxt = chk_vld_r;
        if (chk_stop) begin
          chk_vld_nxt = 1'b0;
          iss_act_nxt = 1'b0;
          state_nxt   = (state_r == S_LEFT) ? S_RSET : S_DRAIN;
        end else begin
          chk_vld_nxt = iss_act_r;
          chk_idx_nxt = iss_idx_r;
          if (state_r == S_LEFT) begin
            iss_act_nxt = iss_act_r && (iss_idx_r != '0);
            iss_idx_nxt = iss_idx_r - 1'b1;
          end else begin
            iss_act_nxt = iss_act_r && (iss_idx_r != last_r);
            iss_idx_nxt = iss_idx_r + 1'b1;
          end
        end
      end
      S_RSET: begin
        chk_vld_nxt = 1'b0;
        if (pi_r != last_r) begin
          iss_idx_nxt = pi_r + 1'b1;
          iss_act_nxt = 1'b1;
          state_nxt   = S_RIGHT;
        end else begin
          iss_act_nxt = 1'b0;
          state_nxt   = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_coord_nxt = llpc_pkg::COORD_W'(lc_r) + llpc_pkg::COORD_W'(cfg.line_offset);
          out_pos_nxt   = pos_sat;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sample_count_r <= '0;
      peak_value_r   <= '0;
      peak_index_r   <= '0;
      line_count_r   <= '0;
      iss_act_r      <= 1'b0;
      chk_vld_r      <= 1'b0;
      prod_vld_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      sample_count_r <= sample_count_nxt;
      peak_value_r   <= peak_value_nxt;
      peak_index_r   <= peak_index_nxt;
      line_count_r   <= line_count_nxt;
      iss_act_r      <= iss_act_nxt;
      chk_vld_r      <= chk_vld_nxt;
      prod_vld_r     <= prod_vld_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pk_r        <= pk_nxt;
    pi_r        <= pi_nxt;
    last_r      <= last_nxt;
    lc_r        <= lc_nxt;
    iss_idx_r   <= iss_idx_nxt;
    chk_idx_r   <= chk_idx_nxt;
    prod_w_r    <= prod_w_nxt;
    prod_v_r    <= prod_v_nxt;
    wacc_r      <= wacc_nxt;
    vacc_r      <= vacc_nxt;
    out_coord_r <= out_coord_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_line_coord = out_coord_r;
  assign out_position   = out_pos_r;

  // left walk only visits samples below the peak
  `LLPC_ASSERT(a_left_walk, clk, rst_n, (state_r == S_LEFT && chk_vld_r) |-> (chk_idx_r < pi_r))
  // right walk stays between the peak and the end of the line
  `LLPC_ASSERT(a_right_walk, clk, rst_n,
    (state_r == S_RIGHT && chk_vld_r) |-> (chk_idx_r > pi_r && chk_idx_r <= last_r))
  // the divisor always contains the peak sample
  `LLPC_ASSERT(a_div_sum, clk, rst_n, (state_r == S_DIV) |-> (vacc_r >= llpc_pkg::VACC_W'(pk_r)))
  // a result only appears at the end of an evaluation
  `LLPC_ASSERT(a_out_from_fin, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
  // reset leaves the block idle with nothing pending
  `LLPC_ASSERT_RST(a_reset_idle, clk, !rst_n |=> (state_r == S_IDLE && !out_valid_r))

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// laser line peak centroid core testbench
// Streams image lines through the in_ channel in random bursts and predicts
// the centroid transfer of every closed line. Each out_ transfer is checked
// field by field against the oldest prediction while the receiver stalls on
// patterns of its own. Registers are rewritten between phases over the apb
// port, and each write is read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import llpc_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int EVAL_IDLE   = LINE_LEN + 64;
  localparam int HOLD_CYCLES = 3000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_ITEMS  = 200;
  localparam int SHORT_LINES = 60;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                eol;
    logic                sof;
  } sample_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] line_coord;
    logic [POS_W-1:0]   position;
  } centroid_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic                in_last_of_line = 1'b0;
  logic                in_start_of_frame = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [COORD_W-1:0]  out_line_coord;
  logic [POS_W-1:0]    out_position;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  laser_line_peak_centroid_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_last_of_line   (in_last_of_line),
    .in_start_of_frame (in_start_of_frame),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_coord    (out_line_coord),
    .out_position      (out_position),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  sample_item_t sample_q[$];
  centroid_t    centroid_q[$];
  int           pushed_items = 0;
  int           accepted_items = 0;
  int           fail_count = 0;
  int           cycle_cnt = 0;

  // shadow of the line tracker and registers
  logic [SAMPLE_W-1:0] line_mem [LINE_LEN];
  logic [SAMPLE_W-1:0] peak_val = '0;
  logic [IDX_W-1:0]    peak_idx = '0;
  logic [CNT_W-1:0]    stored_cnt = '0;
  logic [LINE_W-1:0]   line_ctr = '0;
  cfg_t                cfg_shadow = CFG_RST;

  // driver state
  sample_item_t drv_item;
  int           burst_left = 1;
  int           gap_left = 0;

  // receiver state
  int           stall_mode = 0;
  int           mode_left = 0;
  int           hold_left = 0;
  bit           hold_armed = 1'b0;
  bit           hold_done = 1'b0;

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic void predict_centroid(input logic [SAMPLE_W-1:0] v,
                                           input logic eol, input logic sof);
    int        n;
    int        pk;
    int        pi;
    int        lc;
    int        lo;
    int        hi;
    longint    wsum;
    longint    vsum;
    longint    cent;
    longint    pos;
    centroid_t res;
    if (sof) begin
      line_ctr   = '0;
      stored_cnt = '0;
      peak_val   = '0;
      peak_idx   = '0;
    end
    if (stored_cnt < LINE_LEN) begin
      line_mem[stored_cnt] = v;
      if (stored_cnt == 0 || v > peak_val) begin
        peak_val = v;
        peak_idx = IDX_W'(stored_cnt);
      end
      stored_cnt = stored_cnt + 1'b1;
    end
    if (!eol) return;
    n  = stored_cnt;
    pk = peak_val;
    pi = peak_idx;
    lc = line_ctr;
    stored_cnt = '0;
    peak_val   = '0;
    peak_idx   = '0;
    line_ctr   = line_ctr + 1'b1;
    if (pk < cfg_shadow.min_level || pk == 0 || n == 0 || pi >= n) return;
    lo = pi;
    while (lo > 0) begin
      lo--;
      if (!(5 * int'(line_mem[lo]) > 4 * pk)) break;
    end
    hi = pi;
    while (hi + 1 < n) begin
      hi++;
      if (!(5 * int'(line_mem[hi]) > 4 * pk)) break;
    end
    wsum = 0;
    vsum = 0;
    for (int i = lo; i <= hi; i++) begin
      wsum += longint'(line_mem[i]) * i;
      vsum += longint'(line_mem[i]);
    end
    if (vsum == 0) return;
    cent = (wsum <<< FRAC_BITS) / vsum;
    if (cfg_shadow.integer_position) cent = (cent >>> FRAC_BITS) <<< FRAC_BITS;
    pos = cent + (longint'(cfg_shadow.pos_offset) <<< FRAC_BITS);
    if (pos > longint'(POS_MAX)) pos = longint'(POS_MAX);
    res.line_coord = COORD_W'(lc + int'(cfg_shadow.line_offset));
    res.position   = POS_W'(pos);
    centroid_q.insert(centroid_q.size(), res);
  endfunction

  // driver: bursts of transfers with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      predict_centroid(in_sample, in_last_of_line, in_start_of_frame);
      accepted_items++;
    end
    if (in_valid && in_stall) begin
      in_valid <= 1'b1;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (sample_q.size() > 0) begin
      drv_item = sample_q.pop_front();
      in_valid          <= 1'b1;
      in_sample         <= drv_item.sample;
      in_last_of_line   <= drv_item.eol;
      in_start_of_frame <= drv_item.sof;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 60);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // monitor: checks each result transfer and drives the receiver stall
  always @(posedge clk) begin
    centroid_t exp_res;
    if (out_valid && !out_stall) begin
      if (centroid_q.size() == 0) begin
        $error("unexpected transfer: line_coord %0d position %0d",
               out_line_coord, out_position);
        fail_count++;
      end else begin
        exp_res = centroid_q.pop_front();
        if (out_line_coord !== exp_res.line_coord) begin
          $error("line_coord expected %0d actual %0d", exp_res.line_coord, out_line_coord);
          fail_count++;
        end
        if (out_position !== exp_res.position) begin
          $error("position expected %0d actual %0d", exp_res.position, out_position);
          fail_count++;
        end
      end
    end
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        2: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall <= !out_stall;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_item(input int v, input bit eol, input bit sof);
    sample_item_t it;
    it.sample = SAMPLE_W'(v);
    it.eol    = eol;
    it.sof    = sof;
    sample_q.insert(sample_q.size(), it);
    pushed_items++;
  endtask

  task automatic push_line(input int vals[$], input int sof_at);
    for (int i = 0; i < vals.size(); i++)
      push_item(vals[i], i == vals.size() - 1, i == sof_at);
  endtask

  // stripe, noise or flat line; len 0 picks a mostly short random length
  task automatic add_random_line(input int len_req, input bit bias_full, output int len);
    int vals[$];
    int kind;
    int c;
    int w;
    int pk;
    int flat;
    int d;
    int val;
    int r;
    int sof_at;
    len  = (len_req > 0) ? len_req :
           (($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40));
    kind = $urandom_range(0, 7);
    c    = $urandom_range(0, len - 1);
    w    = $urandom_range(0, 6);
    pk   = (bias_full && $urandom_range(0, 1)) ? 255 : $urandom_range(0, 255);
    flat = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      case (kind)
        6: begin
          val = $urandom_range(0, 255);
        end
        7: begin
          val = flat;
        end
        default: begin
          d = (i > c) ? i - c : c - i;
          if (d <= w) val = pk * (w + 1 - d) / (w + 1);
          else val = $urandom_range(0, 12);
          if ($urandom_range(0, 7) == 0) val += $urandom_range(0, 20);
          if (val > 255) val = 255;
        end
      endcase
      vals.insert(vals.size(), val);
    end
    r = $urandom_range(0, 15);
    if (r < 2) sof_at = 0;
    else if (r == 2) sof_at = $urandom_range(0, len - 1);
    else sof_at = -1;
    push_line(vals, sof_at);
  endtask

  task automatic add_random_lines(input int n_items, input bit bias_full);
    int total;
    int len;
    total = 0;
    while (total < n_items) begin
      add_random_line(0, bias_full, len);
      total += len;
    end
  endtask

  task automatic cfg_write(input logic [REG_SEL_W-1:0] sel, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] exp_val;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({sel, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_MIN_LEVEL: begin
        cfg_shadow.min_level = val[SAMPLE_W-1:0];
        exp_val = DATA_W'(cfg_shadow.min_level);
      end
      REG_LINE_OFFSET: begin
        cfg_shadow.line_offset = val[OFS_W-1:0];
        exp_val = DATA_W'(cfg_shadow.line_offset);
      end
      REG_POS_OFFSET: begin
        cfg_shadow.pos_offset = val[OFS_W-1:0];
        exp_val = DATA_W'(cfg_shadow.pos_offset);
      end
      default: begin
        cfg_shadow.integer_position = val[0];
        exp_val = DATA_W'(cfg_shadow.integer_position);
      end
    endcase
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== exp_val) begin
      $error("prdata expected %0h actual %0h", exp_val, prdata);
      fail_count++;
    end
  endtask

  task automatic cfg_all(input int min_lvl, input int line_ofs, input int pos_ofs,
                         input int int_pos);
    cfg_write(REG_MIN_LEVEL, DATA_W'(min_lvl));
    cfg_write(REG_LINE_OFFSET, DATA_W'(line_ofs));
    cfg_write(REG_POS_OFFSET, DATA_W'(pos_ofs));
    cfg_write(REG_INTEGER_POS, DATA_W'(int_pos));
  endtask

  // all transfers taken, all results seen, last evaluation finished
  task automatic drain();
    while (accepted_items != pushed_items || centroid_q.size() != 0) @(posedge clk);
    repeat (EVAL_IDLE) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset
    push_line('{255}, 0);
    push_line('{50, 200, 200, 30}, -1);
    push_line('{9, 9}, -1);
    push_line('{0, 10, 0}, -1);
    push_line('{255, 255, 255, 255}, -1);
    push_line('{0, 205, 204, 255, 204, 203}, -1);
    push_line('{1, 2, 3, 100, 7, 90}, 3);
    drain();

    cfg_all(0, 4095, 4095, 0);
    push_line('{0, 0, 0}, -1);
    push_line('{0}, -1);
    push_line('{0, 1}, -1);
    add_random_lines(RAND_ITEMS, 1'b0);
    drain();

    cfg_all(255, 0, 0, 1);
    push_line('{254, 254}, -1);
    push_line('{3, 255, 200}, -1);
    add_random_lines(RAND_ITEMS, 1'b1);
    drain();

    // long hold-off on the receiver while lines keep arriving
    cfg_all(1, $urandom_range(0, 4095), $urandom_range(0, 4095), 0);
    add_random_lines(RAND_ITEMS, 1'b0);
    hold_armed = 1'b1;
    drain();

    // one-sample lines, results only on marked lines
    cfg_all(200, 4095, $urandom_range(0, 4095), 1);
    for (int k = 0; k < SHORT_LINES; k++) begin
      if ((k >= SHORT_LINES - 10) || (k % 16 == 0)) push_item(255, 1'b1, k == 0);
      else push_item($urandom_range(0, 199), 1'b1, k == 0);
    end
    drain();

    if (fail_count == 0 && centroid_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
